>>> rtl/bsl_pkg.sv
// Shared definitions for the bounded sequential list: action codes,
// the stored entry layout and the controller state encoding.
// No dependencies.
`default_nettype none

package bsl_pkg;

  localparam int ACT_W     = 4;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 64;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 7;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_INS_BACK   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_INS_SORTED = 4'd2;
  localparam logic [ACT_W-1:0] ACT_RM_FRONT   = 4'd3;
  localparam logic [ACT_W-1:0] ACT_RM_BACK    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_RM_KEY     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_RM_SWAP    = 4'd6;
  localparam logic [ACT_W-1:0] ACT_GET_POS    = 4'd7;
  localparam logic [ACT_W-1:0] ACT_GET_KEY    = 4'd8;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [DATA_W-1:0]       data;
  } entry_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_UP     = 7'b0000100,
    ST_DOWN   = 7'b0001000,
    ST_SWAP   = 7'b0010000,
    ST_FETCH  = 7'b0100000,
    ST_PUT    = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

>>> rtl/bsl_mem.sv
// Entry store for the bounded sequential list: one write port and one
// read port with registered read data. Depends on bsl_pkg.
`default_nettype none

module bsl_mem import bsl_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_entry,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_entry
);

  entry_t mem_r [DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

>>> rtl/bounded_sequential_list.sv
// Top level of the bounded sequential list: request decode, the walking
// controller and the result register. Depends on bsl_pkg and bsl_mem.
//
//   Channel   Ports                                       Transaction when
//   --------  ------------------------------------------  -----------------------
//   request   start, busy, in_action, in_key,             start high, busy low
//             in_entry_data, in_position
//   result    out_valid, out_success, out_found_key,      out_valid high (one
//             out_found_data, out_entry_count,            cycle per request)
//             out_is_full, out_is_empty
//
// Every request yields exactly one result, shown for one cycle after the
// request's last step. Requests refused at acceptance (full, empty, bad
// position, unknown action), removal from the back and removal from the
// front of a one-entry list finish at once (result in the cycle after
// acceptance). Searches walk the stored slots through the single memory
// read port, one slot a cycle, and shifts move one slot a cycle from where
// the search stopped, so a search and its shift together cover the list
// about once.
// Reset (rst_n low, synchronous) empties the list; the slots themselves are
// not cleared since only slots below the count are ever read. The receiver
// cannot stall the result, so busy drops in the cycle the result is loaded.
`default_nettype none

module bounded_sequential_list import bsl_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [ACT_W-1:0]        in_action,
  input  wire logic signed [KEY_W-1:0] in_key,
  input  wire logic [DATA_W-1:0]       in_entry_data,
  input  wire logic [POS_W-1:0]        in_position,
  output logic                         out_valid,
  output logic                         out_success,
  output logic signed [KEY_W-1:0]      out_found_key,
  output logic [DATA_W-1:0]            out_found_data,
  output logic [CNT_OUT_W-1:0]         out_entry_count,
  output logic                         out_is_full,
  output logic                         out_is_empty
);

  // Count width holds ENTRIES itself; slot addresses need one bit less
  // for powers of two.
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  state_t                  state_r, state_nxt;
  logic [ACT_W-1:0]        act_r, act_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0]       data_r, data_nxt;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           tgt_r, tgt_nxt;     // slot being inserted/removed/read
  logic [CW-1:0]           mv_r, mv_nxt;       // next slot to read
  logic                    iss_r, iss_nxt;     // more reads to issue
  logic                    chk_vld_r, chk_vld_nxt;
  logic [CW-1:0]           chk_idx_r, chk_idx_nxt;  // slot of the data now in rd_entry

  logic                    out_valid_r;
  logic                    out_success_r;
  logic signed [KEY_W-1:0] out_found_key_r;
  logic [DATA_W-1:0]       out_found_data_r;
  logic [CNT_OUT_W-1:0]    out_entry_count_r;
  logic                    out_is_full_r;
  logic                    out_is_empty_r;

  logic                    fin;
  logic                    fin_ok;
  entry_t                  fin_entry;
  logic [CW-1:0]           fin_cnt;

  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  entry_t                  mem_wr_entry;
  logic                    mem_rd_en;
  logic [AW-1:0]           mem_rd_addr;
  entry_t                  mem_rd_entry;

  logic                    is_full;
  logic                    is_empty;
  logic [CW-1:0]           cnt_last;
  logic [CW-1:0]           cnt_inc;
  logic [CW-1:0]           idx_up;
  logic [CW-1:0]           idx_dn;
  logic [PW-1:0]           pos_ext;
  logic [PW-1:0]           pos_m1;
  logic                    pos_ok;
  logic                    srch_hit;

  bsl_mem #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_wr_addr),
    .wr_entry (mem_wr_entry),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_rd_addr),
    .rd_entry (mem_rd_entry)
  );

  assign is_full  = (count_r == CW'(ENTRIES));
  assign is_empty = (count_r == '0);
  assign cnt_last = count_r - 1'b1;
  assign cnt_inc  = count_r + 1'b1;
  assign idx_up   = chk_idx_r + 1'b1;
  assign idx_dn   = chk_idx_r - 1'b1;
  assign pos_ext  = PW'(in_position);
  assign pos_m1   = pos_ext - 1'b1;
  assign pos_ok   = (pos_ext != '0) && (pos_ext <= PW'(count_r));

  // A sorted insert stops at the first key not smaller than the new one;
  // the keyed actions stop at the first exact match.
  assign srch_hit = (act_r == ACT_INS_SORTED) ? (mem_rd_entry.key >= key_r)
                                              : (mem_rd_entry.key == key_r);

  // Ordering of the walks keeps reads and writes apart: shifting up reads
  // downward ahead of the writes, shifting down reads upward ahead of the
  // writes, so no slot is read after it was overwritten in the same pass.
  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    key_nxt      = key_r;
    data_nxt     = data_r;
    tgt_nxt      = tgt_r;
    mv_nxt       = mv_r;
    iss_nxt      = iss_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    fin          = 1'b0;
    fin_ok       = 1'b0;
    fin_entry    = '0;
    fin_cnt      = count_r;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = mv_r[AW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = tgt_r[AW-1:0];
    mem_wr_entry = '{key: key_r, data: data_r};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          act_nxt  = in_action;
          key_nxt  = in_key;
          data_nxt = in_entry_data;
          case (in_action)
            ACT_INS_FRONT: begin
              if (is_full) begin
                fin = 1'b1;
              end else if (is_empty) begin
                tgt_nxt   = '0;
                state_nxt = ST_PUT;
              end else begin
                tgt_nxt   = '0;
                mv_nxt    = cnt_last;
                iss_nxt   = 1'b1;
                state_nxt = ST_UP;
              end
            end
            ACT_INS_BACK: begin
              if (is_full) begin
                fin = 1'b1;
              end else begin
                tgt_nxt   = count_r;
                state_nxt = ST_PUT;
              end
            end
            ACT_INS_SORTED: begin
              if (is_full) begin
                fin = 1'b1;
              end else if (is_empty) begin
                tgt_nxt   = '0;
                state_nxt = ST_PUT;
              end else begin
                mv_nxt    = '0;
                state_nxt = ST_SEARCH;
              end
            end
            ACT_RM_FRONT: begin
              if (is_empty) begin
                fin = 1'b1;
              end else if (cnt_last == '0) begin
                fin     = 1'b1;
                fin_ok  = 1'b1;
                fin_cnt = cnt_last;
              end else begin
                tgt_nxt   = '0;
                mv_nxt    = CW'(1);
                iss_nxt   = 1'b1;
                state_nxt = ST_DOWN;
              end
            end
            ACT_RM_BACK: begin
              fin = 1'b1;
              if (!is_empty) begin
                fin_ok  = 1'b1;
                fin_cnt = cnt_last;
              end
            end
            ACT_RM_KEY, ACT_RM_SWAP, ACT_GET_KEY: begin
              if (is_empty) begin
                fin = 1'b1;
              end else begin
                mv_nxt    = '0;
                state_nxt = ST_SEARCH;
              end
            end
            ACT_GET_POS: begin
              if (pos_ok) begin
                tgt_nxt   = pos_m1[CW-1:0];
                iss_nxt   = 1'b1;
                state_nxt = ST_FETCH;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        if (mv_r < count_r) begin
          mem_rd_en   = 1'b1;
          mv_nxt      = mv_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = mv_r;
        end
        if (chk_vld_r && (srch_hit || (chk_idx_r == cnt_last))) begin
          chk_vld_nxt = 1'b0;
          tgt_nxt     = chk_idx_r;
          case (act_r)
            ACT_INS_SORTED: begin
              if (srch_hit) begin
                mv_nxt    = cnt_last;
                iss_nxt   = 1'b1;
                state_nxt = ST_UP;
              end else begin
                tgt_nxt   = count_r;
                state_nxt = ST_PUT;
              end
            end
            ACT_RM_KEY: begin
              if (!srch_hit) begin
                fin = 1'b1;
              end else if (chk_idx_r == cnt_last) begin
                fin     = 1'b1;
                fin_ok  = 1'b1;
                fin_cnt = cnt_last;
              end else begin
                mv_nxt    = idx_up;
                iss_nxt   = 1'b1;
                state_nxt = ST_DOWN;
              end
            end
            ACT_RM_SWAP: begin
              if (srch_hit) begin
                mv_nxt    = cnt_last;
                iss_nxt   = 1'b1;
                state_nxt = ST_SWAP;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
              if (srch_hit) begin
                fin_ok    = 1'b1;
                fin_entry = mem_rd_entry;
              end
            end
          endcase
        end
      end

      ST_UP: begin
        if (iss_r) begin
          mem_rd_en   = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = mv_r;
          if (mv_r == tgt_r) begin
            iss_nxt = 1'b0;
          end else begin
            mv_nxt = mv_r - 1'b1;
          end
        end
        if (chk_vld_r) begin
          mem_wr_en    = 1'b1;
          mem_wr_addr  = idx_up[AW-1:0];
          mem_wr_entry = mem_rd_entry;
          if (chk_idx_r == tgt_r) begin
            state_nxt = ST_PUT;
          end
        end
      end

      ST_DOWN: begin
        if (iss_r) begin
          mem_rd_en   = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = mv_r;
          if (mv_r == cnt_last) begin
            iss_nxt = 1'b0;
          end else begin
            mv_nxt = mv_r + 1'b1;
          end
        end
        if (chk_vld_r) begin
          mem_wr_en    = 1'b1;
          mem_wr_addr  = idx_dn[AW-1:0];
          mem_wr_entry = mem_rd_entry;
          if (chk_idx_r == cnt_last) begin
            fin     = 1'b1;
            fin_ok  = 1'b1;
            fin_cnt = cnt_last;
          end
        end
      end

      ST_SWAP: begin
        if (iss_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt_last[AW-1:0];
          iss_nxt     = 1'b0;
        end else begin
          mem_wr_en    = 1'b1;
          mem_wr_entry = mem_rd_entry;
          fin          = 1'b1;
          fin_ok       = 1'b1;
          fin_cnt      = cnt_last;
        end
      end

      ST_FETCH: begin
        if (iss_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = tgt_r[AW-1:0];
          iss_nxt     = 1'b0;
        end else begin
          fin       = 1'b1;
          fin_ok    = 1'b1;
          fin_entry = mem_rd_entry;
        end
      end

      ST_PUT: begin
        mem_wr_en = 1'b1;
        fin       = 1'b1;
        fin_ok    = 1'b1;
        fin_cnt   = cnt_inc;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
      iss_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      iss_r       <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= fin;
      if (fin) begin
        count_r <= fin_cnt;
      end
    end
  end

  // Request fields, walk pointers and the result hold no reset.
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    data_r    <= data_nxt;
    tgt_r     <= tgt_nxt;
    mv_r      <= mv_nxt;
    chk_idx_r <= chk_idx_nxt;
    if (fin) begin
      out_success_r     <= fin_ok;
      out_found_key_r   <= fin_entry.key;
      out_found_data_r  <= fin_entry.data;
      out_entry_count_r <= CNT_OUT_W'(fin_cnt);
      out_is_full_r     <= (fin_cnt == CW'(ENTRIES));
      out_is_empty_r    <= (fin_cnt == '0);
    end
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_success     = out_success_r;
  assign out_found_key   = out_found_key_r;
  assign out_found_data  = out_found_data_r;
  assign out_entry_count = out_entry_count_r;
  assign out_is_full     = out_is_full_r;
  assign out_is_empty    = out_is_empty_r;

  // The count never passes capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("entry count exceeds capacity");

  // Reads only touch slots that hold entries.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |-> (CW'(mem_rd_addr) < count_r))
    else $error("read of a slot beyond the count");

  // Writes never land beyond the first free slot.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> (CW'(mem_wr_addr) <= count_r))
    else $error("write beyond the first free slot");

  // A refused transaction leaves the count as it was.
  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && !fin_ok) |=> (count_r == $past(count_r)))
    else $error("failed transaction changed the count");

endmodule

`default_nettype wire

>>> tb/tb_bounded_sequential_list.sv
// Self-checking testbench for the bounded sequential list: a shadow copy of
// the list predicts every result, and a monitor compares the block against it.
// Depends on bsl_pkg and bounded_sequential_list from the rtl folder.
`timescale 1ns / 100ps

module tb_bounded_sequential_list;
  import bsl_pkg::*;

  localparam int LIST_ENTRIES   = 64;
  localparam int RANDOM_ITEMS   = 450;
  localparam int IDLE_PCT       = 19;
  // A search and the shift after it cover the list about once, which bounds
  // the slowest request. The watchdog allows several times that with no
  // transaction.
  localparam int SLOWEST_ITEM   = LIST_ENTRIES + 3;
  localparam int WATCHDOG_LIMIT = 8 * SLOWEST_ITEM;
  // Action codes above the last defined one are refused by the block.
  localparam int unsigned ACT_FIRST_UNUSED = ACT_GET_KEY + 1;
  localparam int unsigned ACT_CODE_MAX     = (1 << ACT_W) - 1;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  // One predicted result transaction, laid out like the result ports.
  typedef struct packed {
    logic                    success;
    logic signed [KEY_W-1:0] found_key;
    logic [DATA_W-1:0]       found_data;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    is_full;
    logic                    is_empty;
  } list_result_t;

  // Shadow copy of the list. Every accepted request is applied to it and
  // the result it should produce is queued until the block delivers one.
  class ShadowList;
    logic signed [KEY_W-1:0] keys [LIST_ENTRIES];
    logic [DATA_W-1:0]       payloads [LIST_ENTRIES];
    int                      count;
    list_result_t            awaited_results [$];
    int                      errors;
    int                      results_seen;

    function new();
      count = 0;
      errors = 0;
      results_seen = 0;
    endfunction

    // Index of the first slot holding the key, or count when it is absent.
    function int find_key(logic signed [KEY_W-1:0] key);
      int i;
      i = 0;
      while (i < count && keys[i] != key) i++;
      return i;
    endfunction

    // Shift later entries up one slot and write the new entry at slot at.
    function void open_slot(int at, logic signed [KEY_W-1:0] key, logic [DATA_W-1:0] data);
      for (int j = count; j > at; j--) begin
        keys[j] = keys[j-1];
        payloads[j] = payloads[j-1];
      end
      keys[at] = key;
      payloads[at] = data;
      count++;
    endfunction

    // Close the gap at slot at by shifting later entries down.
    function void close_slot(int at);
      for (int j = at; j + 1 < count; j++) begin
        keys[j] = keys[j+1];
        payloads[j] = payloads[j+1];
      end
      count--;
    endfunction

    function logic signed [KEY_W-1:0] pick_stored_key();
      return keys[$urandom_range(count - 1)];
    endfunction

    function void apply_request(logic [ACT_W-1:0] action, logic signed [KEY_W-1:0] key,
                                logic [DATA_W-1:0] data, logic [POS_W-1:0] pos);
      list_result_t res;
      int           i;
      bit           full;
      res = '0;
      full = (count >= LIST_ENTRIES);
      case (action)
        ACT_INS_FRONT: begin
          if (!full) begin
            open_slot(0, key, data);
            res.success = 1'b1;
          end
        end
        ACT_INS_BACK: begin
          if (!full) begin
            open_slot(count, key, data);
            res.success = 1'b1;
          end
        end
        ACT_INS_SORTED: begin
          if (!full) begin
            i = 0;
            while (i < count && keys[i] < key) i++;
            open_slot(i, key, data);
            res.success = 1'b1;
          end
        end
        ACT_RM_FRONT: begin
          if (count > 0) begin
            close_slot(0);
            res.success = 1'b1;
          end
        end
        ACT_RM_BACK: begin
          if (count > 0) begin
            count--;
            res.success = 1'b1;
          end
        end
        ACT_RM_KEY: begin
          i = find_key(key);
          if (i < count) begin
            close_slot(i);
            res.success = 1'b1;
          end
        end
        ACT_RM_SWAP: begin
          i = find_key(key);
          if (i < count) begin
            count--;
            keys[i] = keys[count];
            payloads[i] = payloads[count];
            res.success = 1'b1;
          end
        end
        ACT_GET_POS: begin
          if (pos >= 1 && pos <= count) begin
            res.found_key = keys[pos-1];
            res.found_data = payloads[pos-1];
            res.success = 1'b1;
          end
        end
        ACT_GET_KEY: begin
          i = find_key(key);
          if (i < count) begin
            res.found_key = keys[i];
            res.found_data = payloads[i];
            res.success = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res.entry_count = count[CNT_OUT_W-1:0];
      res.is_full = (count == LIST_ENTRIES);
      res.is_empty = (count == 0);
      awaited_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      if (errors < 100) $display("ERROR at %0t, result %0d: %s", $realtime, results_seen, what);
      errors++;
    endtask

    task compare_result(logic success, logic signed [KEY_W-1:0] found_key,
                        logic [DATA_W-1:0] found_data, logic [CNT_OUT_W-1:0] entry_count,
                        logic is_full, logic is_empty);
      list_result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request waiting for it");
      end else begin
        want = awaited_results.pop_front();
        if (success !== want.success)
          report_mismatch($sformatf("success %b, expected %b", success, want.success));
        if (found_key !== want.found_key)
          report_mismatch($sformatf("found_key %h, expected %h", found_key, want.found_key));
        if (found_data !== want.found_data)
          report_mismatch($sformatf("found_data %h, expected %h", found_data, want.found_data));
        if (entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    entry_count, want.entry_count));
        if (is_full !== want.is_full)
          report_mismatch($sformatf("is_full %b, expected %b", is_full, want.is_full));
        if (is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %b, expected %b", is_empty, want.is_empty));
      end
    endtask
  endclass

  // Every input of the block starts at a known value.
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ACT_W-1:0]        in_action = '0;
  logic signed [KEY_W-1:0] in_key = '0;
  logic [DATA_W-1:0]       in_entry_data = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_success;
  logic signed [KEY_W-1:0] out_found_key;
  logic [DATA_W-1:0]       out_found_data;
  logic [CNT_OUT_W-1:0]    out_entry_count;
  logic                    out_is_full;
  logic                    out_is_empty;

  bit        gaps_on = 1'b1;
  ShadowList shadow = new();

  bounded_sequential_list #(.ENTRIES(LIST_ENTRIES)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_entry_data  (in_entry_data),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_success    (out_success),
    .out_found_key  (out_found_key),
    .out_found_data (out_found_data),
    .out_entry_count(out_entry_count),
    .out_is_full    (out_is_full),
    .out_is_empty   (out_is_empty)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor. Everything is sampled at the rising edge, while the values
  // driven at the previous falling edge are stable. The result is checked
  // before the request of the same edge is applied, since a request
  // accepted at this edge cannot produce its result at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1)
        shadow.compare_result(out_success, out_found_key, out_found_data,
                              out_entry_count, out_is_full, out_is_empty);
      if (start === 1'b1 && busy === 1'b0)
        shadow.apply_request(in_action, in_key, in_entry_data, in_position);
    end
  end

  // Watchdog: counts cycles in which neither a request nor a result
  // transaction takes place, and ends the run if the count gets too high.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Drives one request transaction. It is called just after a falling edge
  // and returns at the falling edge after the request was accepted. While
  // gaps are on, start may first drop for a few random cycles, which also
  // lands idle cycles in the middle of the block's work on the last request.
  // Start that stays high for the next request is simply left high.
  task automatic send_request(input logic [ACT_W-1:0] action,
                              input logic signed [KEY_W-1:0] key,
                              input logic [DATA_W-1:0] data,
                              input logic [POS_W-1:0] pos);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_action     <= action;
    in_key        <= key;
    in_entry_data <= data;
    in_position   <= pos;
    do @(posedge clk); while (!(start === 1'b1 && busy === 1'b0));
    @(negedge clk);
  endtask

  // Keys come mostly from a small window around zero so that searches hit
  // and duplicates build up; the rest are extremes or fully random.
  function automatic logic signed [KEY_W-1:0] random_key();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 60) return int'($urandom_range(16)) - 8;
    if (pick < 75) begin
      case ($urandom_range(3))
        0:       return KEY_MIN;
        1:       return KEY_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin : stimulus
    logic [ACT_W-1:0]        act;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        pos;
    int unsigned             pick;
    int                      ins_pct;
    int                      rm_pct;
    int                      pos_limit;

    // Synchronous reset held at the start of the run.
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Every removal and fetch on the empty list must be
    // refused, including position zero.
    send_request(ACT_RM_FRONT, '0, '0, '0);
    send_request(ACT_RM_BACK, '0, '0, '0);
    send_request(ACT_RM_KEY, '0, '0, '0);
    send_request(ACT_RM_SWAP, '0, '0, '0);
    send_request(ACT_GET_POS, '0, '0, POS_W'(1));
    send_request(ACT_GET_POS, '0, '0, '0);
    send_request(ACT_GET_KEY, '0, '0, '0);
    // Fill with the extreme keys and payloads, then sorted inserts with a
    // duplicate key: the list becomes MIN, -1, 0, 0, MAX.
    send_request(ACT_INS_BACK, KEY_MIN, '1, '0);
    send_request(ACT_INS_BACK, KEY_MAX, '0, '0);
    send_request(ACT_INS_SORTED, '0, 64'h0123_4567_89ab_cdef, '0);
    send_request(ACT_INS_SORTED, '1, 64'hfedc_ba98_7654_3210, '0);
    send_request(ACT_INS_SORTED, '0, 64'haaaa_5555_aaaa_5555, '0);
    send_request(ACT_INS_FRONT, 32'sd12, 64'h5555_aaaa_5555_aaaa, '0);
    // Fetch by position: first, last, one beyond, the top of the range.
    send_request(ACT_GET_POS, '0, '0, POS_W'(1));
    send_request(ACT_GET_POS, '0, '0, POS_W'(6));
    send_request(ACT_GET_POS, '0, '0, POS_W'(7));
    send_request(ACT_GET_POS, '0, '0, POS_W'(LIST_ENTRIES));
    // A duplicate key is found at its lowest slot; a missing key misses.
    send_request(ACT_GET_KEY, '0, '0, '0);
    send_request(ACT_GET_KEY, 32'sd12345, '0, '0);
    send_request(ACT_RM_KEY, 32'sd12345, '0, '0);
    send_request(ACT_RM_KEY, '0, '0, '0);
    send_request(ACT_RM_SWAP, KEY_MIN, '0, '0);
    send_request(ACT_RM_FRONT, '0, '0, '0);
    // Unknown actions leave the list alone.
    send_request(ACT_W'(ACT_FIRST_UNUSED), '1, '1, '1);
    send_request(ACT_W'(ACT_CODE_MAX), '0, '0, '0);

    // Random part in three phases: one that mostly inserts and runs into
    // the full list, a balanced one, and one that mostly removes and runs
    // the list dry. A stretch in the middle runs without any gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 200 && n < 300);
      case (n / 150)
        0: begin
          ins_pct = 60;
          rm_pct  = 15;
        end
        1: begin
          ins_pct = 35;
          rm_pct  = 35;
        end
        default: begin
          ins_pct = 15;
          rm_pct  = 55;
        end
      endcase
      pick = $urandom_range(99);
      if (pick < 3) begin
        act = ACT_W'($urandom_range(ACT_CODE_MAX, ACT_FIRST_UNUSED));
      end else if (pick < 3 + ins_pct) begin
        case ($urandom_range(2))
          0:       act = ACT_INS_FRONT;
          1:       act = ACT_INS_BACK;
          default: act = ACT_INS_SORTED;
        endcase
      end else if (pick < 3 + ins_pct + rm_pct) begin
        case ($urandom_range(3))
          0:       act = ACT_RM_FRONT;
          1:       act = ACT_RM_BACK;
          2:       act = ACT_RM_KEY;
          default: act = ACT_RM_SWAP;
        endcase
      end else begin
        act = $urandom_range(1) ? ACT_GET_POS : ACT_GET_KEY;
      end
      // Keyed searches mostly look for a key that is really stored.
      if ((act == ACT_RM_KEY || act == ACT_RM_SWAP || act == ACT_GET_KEY) &&
          shadow.count > 0 && $urandom_range(99) < 65)
        key = shadow.pick_stored_key();
      else
        key = random_key();
      pos_limit = (shadow.count < LIST_ENTRIES) ? shadow.count + 1 : LIST_ENTRIES;
      if ($urandom_range(99) < 80)
        pos = POS_W'($urandom_range(pos_limit));
      else
        pos = POS_W'($urandom_range(LIST_ENTRIES));
      send_request(act, key, {$urandom, $urandom}, pos);
    end
    start <= 1'b0;

    // Wait for every outstanding result, then watch a while longer for
    // stray results before the verdict.
    while (shadow.awaited_results.size() != 0) @(posedge clk);
    repeat (SLOWEST_ITEM + 8) @(posedge clk);
    if (shadow.errors == 0 && shadow.awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bsl_pkg.sv
rtl/bsl_mem.sv
rtl/bounded_sequential_list.sv
tb/tb_bounded_sequential_list.sv
